/* rtl/ssg_pkg.sv */
// Shared constants, item types and the rotation angle table of the sine sample generator.
`timescale 1ns / 1ps

package ssg_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 4096;
   localparam int DEFAULT_ANGLE_BITS  = 16;

   localparam int INDEX_BITS  = 12;
   localparam int AMP_BITS    = 10;
   localparam int PHASE_BITS  = 16;
   localparam int COUNT_BITS  = 13;
   localparam int SAMPLE_BITS = 20;
   localparam int TURN_BITS   = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 13'd64;

   localparam int ROT_STEPS   = 24;
   localparam int CORDIC_BITS = 33;
   localparam logic signed [CORDIC_BITS-1:0] START_X = 33'sd922113735;

   localparam int OUT_LIMIT = 370400;

   // turn fraction plus amplitude, leaving the angle stage
   typedef struct packed {
      logic                  valid;
      logic [TURN_BITS-1:0]  turn;
      logic [AMP_BITS-1:0]   amp;
   } turn_item_type;

   // sqrt(2)*sin in Q30 plus amplitude, leaving the rotation pipeline
   typedef struct packed {
      logic                          valid;
      logic signed [CORDIC_BITS-1:0] value;
      logic [AMP_BITS-1:0]           amp;
   } sine_item_type;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] sample;
   } sample_item_type;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32
   function automatic logic signed [CORDIC_BITS-1:0] rot_angle(input int step);
      logic signed [CORDIC_BITS-1:0] angle;
      case (step)
         0:       angle = 33'sh020000000;
         1:       angle = 33'sh012E4051D;
         2:       angle = 33'sh009FB385B;
         3:       angle = 33'sh0051111D4;
         4:       angle = 33'sh0028B0D43;
         5:       angle = 33'sh00145D7E1;
         6:       angle = 33'sh000A2F61E;
         7:       angle = 33'sh000517C55;
         8:       angle = 33'sh00028BE53;
         9:       angle = 33'sh000145F2F;
         10:      angle = 33'sh0000A2F98;
         11:      angle = 33'sh0000517CC;
         12:      angle = 33'sh000028BE6;
         13:      angle = 33'sh0000145F3;
         14:      angle = 33'sh00000A2F9;
         15:      angle = 33'sh00000517D;
         16:      angle = 33'sh0000028BE;
         17:      angle = 33'sh00000145F;
         18:      angle = 33'sh000000A30;
         19:      angle = 33'sh000000518;
         20:      angle = 33'sh00000028C;
         21:      angle = 33'sh000000146;
         22:      angle = 33'sh0000000A3;
         23:      angle = 33'sh000000051;
         default: angle = '0;
      endcase
      return angle;
   endfunction

endpackage

/* rtl/ssg_divider.sv */
// Pipelined restoring divider for the sample angle, one quotient bit per stage, plus phase add.
`timescale 1ns / 1ps

module ssg_divider
   import ssg_pkg::*;
#(
   parameter int ANGLE_BITS   = DEFAULT_ANGLE_BITS,
   parameter int DIVISOR_BITS = COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    req_valid,
   input  logic [INDEX_BITS-1:0]   sample_index,
   input  logic [AMP_BITS-1:0]     amplitude_rms,
   input  logic [PHASE_BITS-1:0]   phase_turn,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output turn_item_type           turn_out
);

   // dividend is sample_index followed by ANGLE_BITS zero bits
   localparam int STAGES = INDEX_BITS + ANGLE_BITS;

   logic                    valid_ff [STAGES];
   logic [DIVISOR_BITS-1:0] rem_ff   [STAGES];
   logic [DIVISOR_BITS-1:0] rem_in   [STAGES];
   logic [ANGLE_BITS-1:0]   quot_ff  [STAGES];
   logic [ANGLE_BITS-1:0]   quot_in  [STAGES];
   logic [ANGLE_BITS-1:0]   phase_ff [STAGES];
   logic [INDEX_BITS-1:0]   index_ff [STAGES];
   logic [AMP_BITS-1:0]     amp_ff   [STAGES];

   logic [ANGLE_BITS+PHASE_BITS-1:0] phase_wide;
   logic [ANGLE_BITS-1:0]            phase_scaled;
   logic [ANGLE_BITS-1:0]            angle_sum;
   turn_item_type                    turn_ff;
   turn_item_type                    turn_in;

   // phase * 2^ANGLE_BITS / 2^16, low bits dropped
   assign phase_wide   = {phase_turn, {ANGLE_BITS{1'b0}}};
   assign phase_scaled = phase_wide[ANGLE_BITS+PHASE_BITS-1:PHASE_BITS];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                    valid_cur;
      logic [DIVISOR_BITS-1:0] rem_cur;
      logic [ANGLE_BITS-1:0]   quot_cur;
      logic [ANGLE_BITS-1:0]   phase_cur;
      logic [INDEX_BITS-1:0]   index_cur;
      logic [AMP_BITS-1:0]     amp_cur;
      logic                    dbit;
      logic [DIVISOR_BITS:0]   partial;
      logic [DIVISOR_BITS:0]   diff;
      logic                    take;

      if (k == 0) begin : g_first
         assign valid_cur = req_valid;
         assign rem_cur   = '0;
         assign quot_cur  = '0;
         assign phase_cur = phase_scaled;
         assign index_cur = sample_index;
         assign amp_cur   = amplitude_rms;
      end else begin : g_next
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign quot_cur  = quot_ff[k-1];
         assign phase_cur = phase_ff[k-1];
         assign index_cur = index_ff[k-1];
         assign amp_cur   = amp_ff[k-1];
      end

      if (k < INDEX_BITS) begin : g_index_bit
         assign dbit = index_cur[INDEX_BITS-1-k];
      end else begin : g_zero_bit
         assign dbit = 1'b0;
      end

      // no borrow means the shifted remainder reaches the divisor
      assign partial = {rem_cur, dbit};
      assign diff    = partial - {1'b0, divisor};
      assign take    = ~diff[DIVISOR_BITS];

      assign rem_in[k]  = take ? diff[DIVISOR_BITS-1:0] : partial[DIVISOR_BITS-1:0];
      assign quot_in[k] = {quot_cur[ANGLE_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]   <= rem_in[k];
            quot_ff[k]  <= quot_in[k];
            phase_ff[k] <= phase_cur;
            index_ff[k] <= index_cur;
            amp_ff[k]   <= amp_cur;
         end
      end
   end

   // angle wraps modulo a full turn
   assign angle_sum     = quot_ff[STAGES-1] + phase_ff[STAGES-1];
   assign turn_in.valid = valid_ff[STAGES-1];
   assign turn_in.turn  = {angle_sum, {(TURN_BITS-ANGLE_BITS){1'b0}}};
   assign turn_in.amp   = amp_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff.valid <= 1'b0;
      end else if (en) begin
         turn_ff.valid <= turn_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         turn_ff.turn <= turn_in.turn;
         turn_ff.amp  <= turn_in.amp;
      end
   end

   assign turn_out = turn_ff;

endmodule

/* rtl/ssg_cordic.sv */
// Rotation pipeline: one CORDIC step per stage, then quadrant mapping of sqrt(2)*sin.
`timescale 1ns / 1ps

module ssg_cordic
   import ssg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  turn_item_type turn_in,
   output sine_item_type sine_out
);

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   logic                          valid_ff [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] x_ff     [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] y_ff     [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] z_ff     [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] x_in     [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] y_in     [ROT_STEPS];
   logic signed [CORDIC_BITS-1:0] z_in     [ROT_STEPS];
   logic [1:0]                    quad_ff  [ROT_STEPS];
   logic [AMP_BITS-1:0]           amp_ff   [ROT_STEPS];

   sine_item_type sine_ff;
   sine_item_type sine_in;

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_step
      logic                          valid_cur;
      logic signed [CORDIC_BITS-1:0] x_cur;
      logic signed [CORDIC_BITS-1:0] y_cur;
      logic signed [CORDIC_BITS-1:0] z_cur;
      logic [1:0]                    quad_cur;
      logic [AMP_BITS-1:0]           amp_cur;
      logic signed [CORDIC_BITS-1:0] dx;
      logic signed [CORDIC_BITS-1:0] dy;

      if (i == 0) begin : g_first
         // gain correction and sqrt(2) sit in the start vector
         assign valid_cur = turn_in.valid;
         assign x_cur     = START_X;
         assign y_cur     = '0;
         assign z_cur     = signed'({{(CORDIC_BITS-TURN_BITS+2){1'b0}},
                                     turn_in.turn[TURN_BITS-3:0]});
         assign quad_cur  = turn_in.turn[TURN_BITS-1:TURN_BITS-2];
         assign amp_cur   = turn_in.amp;
      end else begin : g_next
         assign valid_cur = valid_ff[i-1];
         assign x_cur     = x_ff[i-1];
         assign y_cur     = y_ff[i-1];
         assign z_cur     = z_ff[i-1];
         assign quad_cur  = quad_ff[i-1];
         assign amp_cur   = amp_ff[i-1];
      end

      assign dx = y_cur >>> i;
      assign dy = x_cur >>> i;

      always_comb begin
         if (!z_cur[CORDIC_BITS-1]) begin
            x_in[i] = x_cur - dx;
            y_in[i] = y_cur + dy;
            z_in[i] = z_cur - rot_angle(i);
         end else begin
            x_in[i] = x_cur + dx;
            y_in[i] = y_cur - dy;
            z_in[i] = z_cur + rot_angle(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            quad_ff[i] <= quad_cur;
            amp_ff[i]  <= amp_cur;
         end
      end
   end

   always_comb begin
      sine_in.valid = valid_ff[ROT_STEPS-1];
      sine_in.amp   = amp_ff[ROT_STEPS-1];
      case (quad_ff[ROT_STEPS-1])
         QUAD_FIRST:  sine_in.value = y_ff[ROT_STEPS-1];
         QUAD_SECOND: sine_in.value = x_ff[ROT_STEPS-1];
         QUAD_THIRD:  sine_in.value = -y_ff[ROT_STEPS-1];
         QUAD_FOURTH: sine_in.value = -x_ff[ROT_STEPS-1];
         default:     sine_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff.valid <= 1'b0;
      end else if (en) begin
         sine_ff.valid <= sine_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff.value <= sine_in.value;
         sine_ff.amp   <= sine_in.amp;
      end
   end

   assign sine_out = sine_ff;

endmodule

/* rtl/ssg_scale.sv */
// Amplitude multiply, round half away from zero to Q.8 and saturate.
`timescale 1ns / 1ps

module ssg_scale
   import ssg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  sine_item_type   sine_in,
   output sample_item_type sample_out
);

   localparam int PROD_BITS   = AMP_BITS + 1 + CORDIC_BITS;
   localparam int ROUND_SHIFT = 22;
   localparam int MAG_BITS    = PROD_BITS - ROUND_SHIFT;

   logic                        prod_valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [AMP_BITS:0]    amp_signed;

   logic                        mag_valid_ff;
   logic                        mag_neg_ff;
   logic [PROD_BITS-1:0]        mag_ff;
   logic [PROD_BITS-1:0]        mag_in;

   logic [PROD_BITS-1:0]        round_sum;
   logic [MAG_BITS-1:0]         rounded;
   logic [SAMPLE_BITS-1:0]      limited;
   sample_item_type             sample_ff;
   sample_item_type             sample_in;

   assign amp_signed = signed'({1'b0, sine_in.amp});
   assign prod_in    = amp_signed * sine_in.value;

   assign mag_in = prod_ff[PROD_BITS-1] ? unsigned'(-prod_ff) : unsigned'(prod_ff);

   assign round_sum = mag_ff + (PROD_BITS'(1) << (ROUND_SHIFT - 1));
   assign rounded   = round_sum[PROD_BITS-1:ROUND_SHIFT];

   always_comb begin
      if (rounded > MAG_BITS'(OUT_LIMIT)) begin
         limited = SAMPLE_BITS'(OUT_LIMIT);
      end else begin
         limited = rounded[SAMPLE_BITS-1:0];
      end
      sample_in.valid  = mag_valid_ff;
      sample_in.sample = mag_neg_ff ? signed'(-limited) : signed'(limited);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff   <= 1'b0;
         mag_valid_ff    <= 1'b0;
         sample_ff.valid <= 1'b0;
      end else if (en) begin
         prod_valid_ff   <= sine_in.valid;
         mag_valid_ff    <= prod_valid_ff;
         sample_ff.valid <= sample_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff          <= prod_in;
         mag_neg_ff       <= prod_ff[PROD_BITS-1];
         mag_ff           <= mag_in;
         sample_ff.sample <= sample_in.sample;
      end
   end

   assign sample_out = sample_ff;

endmodule

/* rtl/sine_sample_generator.sv */
// Top level of the sine sample generator: count register, pipeline and output skid buffer.
`timescale 1ns / 1ps

// Sine sample generator. Each request (sample index, rms amplitude, phase as a 16-bit
// fraction of a turn) yields one sample, rms * sqrt(2) * sin(2*pi*index/count + phase),
// signed Q.8, rounded half away from zero and saturated to +/-370400. One request is
// taken per clock while the skid register is empty. The angle divider resolves one
// quotient bit per stage over 12 + ANGLE_BITS stages plus one for the phase add, the
// rotation pipeline takes 25 stages and scaling 3. When the result side stalls, a skid
// register holds one sample and the whole pipeline freezes until it is taken. The count
// register is clamped on write (zero reads as one, large values as MAX_SAMPLES) and
// must only be written while no request is in flight.
module sine_sample_generator
   import ssg_pkg::*;
#(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
   parameter int ANGLE_BITS  = DEFAULT_ANGLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INDEX_BITS-1:0]         req_sample_index,
   input  logic [AMP_BITS-1:0]           req_amplitude_rms,
   input  logic [PHASE_BITS-1:0]         req_phase_turn,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                          csr_write_enable,
   input  logic [COUNT_BITS-1:0]         csr_write_data
);

   localparam int COUNT_CLOG   = $clog2(MAX_SAMPLES + 1);
   localparam int DIVISOR_BITS = (COUNT_CLOG < COUNT_BITS) ? COUNT_CLOG : COUNT_BITS;

   function automatic logic [DIVISOR_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] value);
      logic [DIVISOR_BITS-1:0] result;
      if (value == '0) begin
         result = DIVISOR_BITS'(1);
      end else if (int'(value) > MAX_SAMPLES) begin
         result = DIVISOR_BITS'(MAX_SAMPLES);
      end else begin
         result = value[DIVISOR_BITS-1:0];
      end
      return result;
   endfunction

   logic [DIVISOR_BITS-1:0]       count_ff;
   logic [DIVISOR_BITS-1:0]       count_in;
   logic                          en;
   turn_item_type                 turn_item;
   sine_item_type                 sine_item;
   sample_item_type               last_item;
   logic                          skid_valid_ff;
   logic                          skid_valid_in;
   logic signed [SAMPLE_BITS-1:0] skid_sample_ff;

   assign count_in = clamp_count(csr_write_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= clamp_count(COUNT_RESET);
      end else if (csr_write_enable) begin
         count_ff <= count_in;
      end
   end

   // pipeline advances only while the skid register is free
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   ssg_divider #(
      .ANGLE_BITS  (ANGLE_BITS),
      .DIVISOR_BITS(DIVISOR_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .req_valid    (req_valid),
      .sample_index (req_sample_index),
      .amplitude_rms(req_amplitude_rms),
      .phase_turn   (req_phase_turn),
      .divisor      (count_ff),
      .turn_out     (turn_item)
   );

   ssg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .turn_in (turn_item),
      .sine_out(sine_item)
   );

   ssg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .sine_in   (sine_item),
      .sample_out(last_item)
   );

   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = ~rsp_ready;
      end else begin
         skid_valid_in = last_item.valid & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_sample_ff <= last_item.sample;
      end
   end

   assign rsp_valid        = skid_valid_ff | last_item.valid;
   assign rsp_sample_value = skid_valid_ff ? skid_sample_ff : last_item.sample;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && int'(count_ff) <= MAX_SAMPLES)
      else $error("sample count register out of range");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_sample_ff))
      else $error("skid register lost a stalled sample");

   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && last_item.valid && !rsp_ready
      |=> skid_valid_ff && skid_sample_ff == $past(last_item.sample))
      else $error("stalled pipeline output not captured");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ready |=> !skid_valid_ff)
      else $error("skid register not released after handshake");
`endif

endmodule

/* bench/sine_sample_checker.sv */
// Checker for the sine sample generator: tracks the count register, predicts and compares samples.
`timescale 1ns / 1ps

module sine_sample_checker
   import ssg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [INDEX_BITS-1:0]         req_sample_index,
   input  logic [AMP_BITS-1:0]           req_amplitude_rms,
   input  logic [PHASE_BITS-1:0]         req_phase_turn,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                          csr_write_enable,
   input  logic [COUNT_BITS-1:0]         csr_write_data,
   output int                            mismatch_total,
   output int                            samples_pending,
   output int                            samples_checked
);

   localparam int ANGLE_BITS  = DEFAULT_ANGLE_BITS;
   localparam int MAX_SAMPLES = DEFAULT_MAX_SAMPLES;

   typedef struct {
      logic [INDEX_BITS-1:0]         index;
      logic [AMP_BITS-1:0]           amp;
      logic [PHASE_BITS-1:0]         phase;
      logic [COUNT_BITS-1:0]         count;
      logic signed [SAMPLE_BITS-1:0] sample;
   } sample_expectation_type;

   sample_expectation_type expected_samples[$];
   sample_expectation_type entry;
   sample_expectation_type head;
   logic [COUNT_BITS-1:0]  count_setting = COUNT_RESET;
   int                     mismatches = 0;
   int                     checked = 0;

   // atan(2^-step) as a 32-bit turn fraction
   function automatic longint atan_turn(input int step);
      case (step)
         0:       return 64'h20000000;
         1:       return 64'h12E4051D;
         2:       return 64'h09FB385B;
         3:       return 64'h051111D4;
         4:       return 64'h028B0D43;
         5:       return 64'h0145D7E1;
         6:       return 64'h00A2F61E;
         7:       return 64'h00517C55;
         8:       return 64'h0028BE53;
         9:       return 64'h00145F2F;
         10:      return 64'h000A2F98;
         11:      return 64'h000517CC;
         12:      return 64'h00028BE6;
         13:      return 64'h000145F3;
         14:      return 64'h0000A2F9;
         15:      return 64'h0000517D;
         16:      return 64'h000028BE;
         17:      return 64'h0000145F;
         18:      return 64'h00000A30;
         19:      return 64'h00000518;
         20:      return 64'h0000028C;
         21:      return 64'h00000146;
         22:      return 64'h000000A3;
         23:      return 64'h00000051;
         default: return 64'h0;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] predict_sample(
      input logic [INDEX_BITS-1:0] index,
      input logic [AMP_BITS-1:0]   amp,
      input logic [PHASE_BITS-1:0] phase,
      input logic [COUNT_BITS-1:0] count
   );
      longint unsigned      period, index_w, phase_scaled, angle, wide_turn;
      logic [TURN_BITS-1:0] turn;
      longint               x, y, z, dx, dy, sine_q30, amp_w, prod, mag, rounded;
      int                   up, dn;
      period = 64'(count);
      if (period == 0) period = 1;
      if (period > MAX_SAMPLES) period = MAX_SAMPLES;
      up = (ANGLE_BITS >= PHASE_BITS) ? ANGLE_BITS - PHASE_BITS : 0;
      dn = (ANGLE_BITS < PHASE_BITS) ? PHASE_BITS - ANGLE_BITS : 0;
      index_w = 64'(index);
      phase_scaled = 64'(phase);
      phase_scaled = (phase_scaled << up) >> dn;
      angle = ((index_w << ANGLE_BITS) / period + phase_scaled) & ((64'd1 << ANGLE_BITS) - 1);
      wide_turn = angle << (TURN_BITS - ANGLE_BITS);
      turn = wide_turn[TURN_BITS-1:0];
      // rotate within the quadrant, then map the quadrant
      z = 64'(turn[29:0]);
      x = 64'(START_X);
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turn(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turn(i);
         end
      end
      case (turn[31:30])
         2'd0:    sine_q30 = y;
         2'd1:    sine_q30 = x;
         2'd2:    sine_q30 = -y;
         default: sine_q30 = -x;
      endcase
      amp_w = 64'(amp);
      prod = amp_w * sine_q30;
      mag = (prod < 0) ? -prod : prod;
      rounded = (mag + 64'sd2097152) >>> 22;
      if (prod < 0) rounded = -rounded;
      if (rounded > OUT_LIMIT) rounded = OUT_LIMIT;
      if (rounded < -OUT_LIMIT) rounded = -OUT_LIMIT;
      return rounded[SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         count_setting = COUNT_RESET;
         expected_samples.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample %0d with no request outstanding",
                                         rsp_sample_value));
            end else begin
               head = expected_samples.pop_front();
               checked++;
               if (rsp_sample_value !== head.sample)
                  report_mismatch($sformatf(
                     "sample_value %0d, wanted %0d (index %0d amp %0d phase %h count %0d)",
                     rsp_sample_value, head.sample, head.index, head.amp, head.phase,
                     head.count));
            end
         end
         if (csr_write_enable) count_setting = csr_write_data;
         if (req_valid && req_ready) begin
            entry.index  = req_sample_index;
            entry.amp    = req_amplitude_rms;
            entry.phase  = req_phase_turn;
            entry.count  = count_setting;
            entry.sample = predict_sample(req_sample_index, req_amplitude_rms,
                                          req_phase_turn, count_setting);
            expected_samples.push_back(entry);
         end
      end
      samples_pending <= expected_samples.size();
      mismatch_total  <= mismatches;
      samples_checked <= checked;
   end

endmodule

/* bench/sine_sample_generator_tb.sv */
// Testbench top for the sine sample generator: clock, reset, request and sample traffic, verdict.
`timescale 1ns / 1ps

module sine_sample_generator_tb;
   import ssg_pkg::*;

   localparam int LATENCY         = DEFAULT_ANGLE_BITS + 41;
   localparam int SETTLE_CYCLES   = LATENCY + 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 34;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [INDEX_BITS-1:0]         req_sample_index = '0;
   logic [AMP_BITS-1:0]           req_amplitude_rms = '0;
   logic [PHASE_BITS-1:0]         req_phase_turn = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_value;
   logic                          csr_write_enable = 1'b0;
   logic [COUNT_BITS-1:0]         csr_write_data = '0;

   int                    mismatch_total;
   int                    samples_pending;
   int                    samples_checked;
   bit                    steady = 1'b0;
   int                    hold_cycles = 0;
   int                    requests_sent = 0;
   int                    settings_used = 1;
   int                    idle_cycles = 0;
   int                    walk_pos = 0;
   logic [COUNT_BITS-1:0] count_now = COUNT_RESET;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sine_sample_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .req_amplitude_rms(req_amplitude_rms),
      .req_phase_turn   (req_phase_turn),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sine_sample_checker sample_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .req_amplitude_rms(req_amplitude_rms),
      .req_phase_turn   (req_phase_turn),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (mismatch_total),
      .samples_pending  (samples_pending),
      .samples_checked  (samples_checked)
   );

   // stall watchdog: no request or sample moving for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles, %0d samples outstanding", idle_cycles,
                  samples_pending);
         $display("sine_sample_generator_tb: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic [INDEX_BITS-1:0] index,
                               input logic [AMP_BITS-1:0]   amp,
                               input logic [PHASE_BITS-1:0] phase);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_index  <= index;
      req_amplitude_rms <= amp;
      req_phase_turn    <= phase;
      do @(posedge clock); while (!(req_valid && req_ready));
      requests_sent++;
   endtask

   task automatic send_random_request();
      int                    period, mode;
      logic [INDEX_BITS-1:0] index;
      logic [AMP_BITS-1:0]   amp;
      logic [PHASE_BITS-1:0] phase;
      period = (count_now == 0) ? 1 :
               (int'(count_now) > DEFAULT_MAX_SAMPLES) ? DEFAULT_MAX_SAMPLES : int'(count_now);
      mode = $urandom_range(0, 7);
      if (mode < 4) begin
         index = INDEX_BITS'($urandom_range(0, period - 1));
      end else if (mode == 4) begin
         // walk the period in order
         index = INDEX_BITS'(walk_pos);
         walk_pos = (walk_pos + 1) % period;
      end else if (mode == 5) begin
         index = $urandom_range(0, 1) ? {INDEX_BITS{1'b1}} : '0;
      end else begin
         index = INDEX_BITS'($urandom());
      end
      if ($urandom_range(0, 7) == 0)
         amp = $urandom_range(0, 1) ? {AMP_BITS{1'b1}} : '0;
      else
         amp = AMP_BITS'($urandom());
      if ($urandom_range(0, 7) == 0)
         phase = $urandom_range(0, 1) ? {PHASE_BITS{1'b1}} : '0;
      else
         phase = PHASE_BITS'($urandom());
      send_request(index, amp, phase);
   endtask

   // drop valid, wait for every sample, then let the pipeline go quiet
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_BITS-1:0] value);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_now = value;
      walk_pos = 0;
      settings_used++;
   endtask

   // sample receiver
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = steady ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && hold_cycles == 0);
      end
   end

   initial begin
      int phase_counts [10] = '{0, 1, 4096, 8191, 4097, 3, 100, 2, 37, 64};
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset count of 64
      send_request(12'd0,    10'd0,    16'h0000);
      send_request(12'd0,    10'd1023, 16'h0000);
      send_request(12'd16,   10'd1023, 16'h0000);
      send_request(12'd32,   10'd1023, 16'h0000);
      send_request(12'd48,   10'd1023, 16'h0000);
      send_request(12'd4095, 10'd1023, 16'h0000);  // index far past the count
      send_request(12'd0,    10'd1023, 16'h4000);
      send_request(12'd0,    10'd1023, 16'hFFFF);
      send_request(12'd63,   10'd1023, 16'hFFFF);  // angle plus phase wraps
      send_request(12'd8,    10'd1023, 16'h8000);
      send_request(12'd1,    10'd1,    16'h0000);
      send_request(12'd5,    10'd1,    16'h1234);
      send_request(12'hAAA,  10'h155,  16'h5555);
      send_request(12'h555,  10'h2AA,  16'hAAAA);
      send_request(12'd4095, 10'd0,    16'hFFFF);
      send_request(12'd24,   10'd1023, 16'h2000);
      send_request(12'd40,   10'd512,  16'hC000);

      phase_counts[9] = $urandom_range(5, 8190);
      for (int p = 0; p < 10; p++) begin
         write_count(COUNT_BITS'(phase_counts[p]));
         n = PHASE_ITEMS;
         steady = (p == 3 || p == 6);
         // long output hold-off while requests keep coming back to back
         if (p == 6) begin
            hold_cycles = HOLD_OFF_CYCLES;
            n = 3 * PHASE_ITEMS;
         end
         for (int k = 0; k < n; k++) send_random_request();
         steady = 1'b0;
      end

      drain_and_settle();
      $display("Covered %0d requests and %0d checked samples over %0d sample-count settings,",
               requests_sent, samples_checked, settings_used);
      $display("including zero and all-ones counts, a %0d-cycle output hold-off and gapless runs.",
               HOLD_OFF_CYCLES);
      if (mismatch_total == 0 && samples_pending == 0) begin
         $display("sine_sample_generator_tb: PASS");
      end else begin
         $display("sine_sample_generator_tb: FAIL");
      end
      $finish;
   end

endmodule
